// ===== design/sha256h_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 message hasher.
package sha256h_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BlkBytes = 64;
  localparam int unsigned BlkW     = BlkBytes * ByteW;
  localparam int unsigned FillW    = 6;
  localparam int unsigned LenW     = 61;
  localparam int unsigned NumRnd   = 64;
  localparam int unsigned RndW     = 6;
  localparam int unsigned NumH     = 8;
  localparam int unsigned IdxW     = 3;

  // Position of the first length byte inside the final block.
  localparam logic [FillW-1:0] LenPos   = 6'd56;
  localparam logic [FillW-1:0] FillLast = 6'd63;
  localparam logic [RndW-1:0]  RndLast  = 6'd63;
  localparam logic [IdxW-1:0]  IdxLast  = 3'd7;
  localparam logic [ByteW-1:0] PadMark  = 8'h80;

  localparam logic [WordW-1:0] InitH [NumH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [WordW-1:0] RoundK [NumRnd] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } sha_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // shift in a message byte
    logic pad;       // shift in a padding byte
    logic start;     // copy the chain value into the working registers
    logic round;     // run one compression round
    logic fold;      // add the working registers into the chain value
    logic out_next;  // advance to the next digest word
    logic clear;     // return to the initial message state
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;  // next byte completes the block
    logic final_blk;  // block being padded carries the length
    logic rnd_last;   // last round of the block
    logic out_last;   // digest word seven is on the output
  } sha_status_t;

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
    sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
    sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== design/sha256h_ctrl.sv =====
// Control state machine of the SHA-256 message hasher.
module sha256h_ctrl import sha256h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  sha_status_t status_i,
  output sha_cmd_t    cmd_o
);

  sha_state_e state_q, state_d;
  logic       end_pend_q, end_pend_d;   // message ended, padding still owed
  logic       last_blk_q, last_blk_d;   // block in the rounds carries the length
  logic       in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      end_pend_q <= 1'b0;
      last_blk_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_pend_q <= end_pend_d;
      last_blk_q <= last_blk_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    end_pend_d  = end_pend_q;
    last_blk_d  = last_blk_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          cmd_o.load = byte_present_i;
          if (byte_present_i && status_i.fill_last) begin
            cmd_o.start = 1'b1;
            end_pend_d  = end_of_message_i;
            last_blk_d  = 1'b0;
            state_d     = ST_ROUND;
          end else if (end_of_message_i) begin
            end_pend_d = 1'b1;
            state_d    = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (status_i.rnd_last) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (last_blk_q) begin
          state_d = ST_OUT;
        end else if (end_pend_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.start = 1'b1;
          last_blk_d  = status_i.final_blk;
          state_d     = ST_ROUND;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          if (status_i.out_last) begin
            cmd_o.clear = 1'b1;
            end_pend_d  = 1'b0;
            last_blk_d  = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sha256h_dp.sv =====
// Datapath of the SHA-256 message hasher: block shift line, rounds, chain value.
module sha256h_dp import sha256h_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_cmd_t          cmd_i,
  input  logic [ByteW-1:0]  data_byte_i,
  output sha_status_t       status_o,
  output logic [WordW-1:0]  digest_word_o,
  output logic [IdxW-1:0]   word_index_o
);

  logic [BlkW-1:0]   blk_q, blk_d;
  logic [WordW-1:0]  wk_q [NumH];
  logic [WordW-1:0]  wk_d [NumH];
  logic [WordW-1:0]  h_q  [NumH];
  logic [FillW-1:0]  fill_q;
  logic [LenW-1:0]   len_q;
  logic [RndW-1:0]   rnd_q;
  logic [IdxW-1:0]   idx_q;
  logic              sent80_q;
  logic              len_blk_q;

  logic              len_blk_eff;
  logic [63:0]       len_bits;
  logic [IdxW-1:0]   len_sel;
  logic [ByteW-1:0]  len_byte;
  logic [ByteW-1:0]  pad_byte;
  logic [WordW-1:0]  w_new, t1, t2;

  // The 0x80 marker decides whether the length fits behind it in this block.
  assign len_blk_eff = sent80_q ? len_blk_q : (fill_q < LenPos);
  assign len_bits    = {len_q, 3'b000};
  assign len_sel     = IdxLast - fill_q[IdxW-1:0];
  assign len_byte    = len_bits[{len_sel, 3'b000} +: ByteW];

  always_comb begin
    if (!sent80_q) begin
      pad_byte = PadMark;
    end else if (len_blk_eff && (fill_q >= LenPos)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
  end

  // Schedule word t+16 from words t, t+1, t+9 and t+14 of the window.
  assign w_new = sml_sig1(blk_q[63:32]) + blk_q[223:192]
               + sml_sig0(blk_q[479:448]) + blk_q[511:480];

  assign t1 = wk_q[7] + big_sig1(wk_q[4])
            + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
            + RoundK[rnd_q] + blk_q[511:480];
  assign t2 = big_sig0(wk_q[0])
            + ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));

  always_comb begin
    blk_d = blk_q;
    wk_d  = wk_q;
    if (cmd_i.load) begin
      blk_d = {blk_q[BlkW-ByteW-1:0], data_byte_i};
    end else if (cmd_i.pad) begin
      blk_d = {blk_q[BlkW-ByteW-1:0], pad_byte};
    end else if (cmd_i.round) begin
      blk_d = {blk_q[BlkW-WordW-1:0], w_new};
    end
    if (cmd_i.start) begin
      wk_d = h_q;
    end else if (cmd_i.round) begin
      wk_d[0] = t1 + t2;
      wk_d[1] = wk_q[0];
      wk_d[2] = wk_q[1];
      wk_d[3] = wk_q[2];
      wk_d[4] = wk_q[3] + t1;
      wk_d[5] = wk_q[4];
      wk_d[6] = wk_q[5];
      wk_d[7] = wk_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    wk_q  <= wk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q       <= InitH;
      fill_q    <= '0;
      len_q     <= '0;
      rnd_q     <= '0;
      idx_q     <= '0;
      sent80_q  <= 1'b0;
      len_blk_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        h_q       <= InitH;
        fill_q    <= '0;
        len_q     <= '0;
        sent80_q  <= 1'b0;
        len_blk_q <= 1'b0;
      end else begin
        if (cmd_i.load) begin
          fill_q <= fill_q + 1'b1;
          len_q  <= len_q + 1'b1;
        end
        if (cmd_i.pad) begin
          fill_q    <= fill_q + 1'b1;
          sent80_q  <= 1'b1;
          // Once a block fills up here, the next padded block carries the length.
          len_blk_q <= (fill_q == FillLast) ? 1'b1 : len_blk_eff;
        end
        if (cmd_i.fold) begin
          for (int i = 0; i < NumH; i++) begin
            h_q[i] <= h_q[i] + wk_q[i];
          end
        end
      end
      if (cmd_i.start) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (cmd_i.out_next) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign status_o.fill_last = (fill_q == FillLast);
  assign status_o.final_blk = len_blk_eff;
  assign status_o.rnd_last  = (rnd_q == RndLast);
  assign status_o.out_last  = (idx_q == IdxLast);

  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;

endmodule

// ===== design/sha256_message_hasher_core.sv =====
// Top level of the SHA-256 message hasher: byte stream in, digest words out.
//
//  channel  | dir | tdata (low bit up)    | tuser             | tlast
//  ---------+-----+-----------------------+-------------------+----------------
//  s_axis   | in  | data_byte [7:0]       | byte_present [0]  | end_of_message
//  m_axis   | out | digest_word [31:0]    | word_index [2:0]  | last_word
//
// Cycles: one beat a cycle is taken while a block fills. The beat that brings
// the 64th byte starts the rounds and then the fold, one round at a time on the
// single shared round unit; s_axis_tready stays low meanwhile. An end beat
// starts padding, one byte a cycle through the block shift line up to the end
// of the block, and through a second block when the length spills into it; each
// padded block then runs the rounds and the fold, and eight output beats follow.
// Reset: asynchronous, active low; chain value returns to the initial hash,
// counts to zero. No clearing pass.
// Stalls: m_axis_tready low holds the current digest word; no input is taken
// until the eighth word is gone.
module sha256_message_hasher_core import sha256h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  sha_cmd_t    cmd;
  sha_status_t status;

  // Controller: sequences load, rounds, padding and the digest beats.
  sha256h_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .byte_present_i   (s_axis_tuser_i[0]),
    .end_of_message_i (s_axis_tlast_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  // Datapath: block shift line, working registers and chain value.
  sha256h_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i),
    .status_o      (status),
    .digest_word_o (m_axis_tdata_o),
    .word_index_o  (m_axis_tuser_o)
  );

  // Word seven closes the digest.
  assign m_axis_tlast_o = status.out_last;

endmodule

// ===== design/sha256h_checker.sv =====
// Port-level checks of the SHA-256 message hasher, bound to the top level.
module sha256h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // No input beat is taken while the digest goes out.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while digest pending");

  // A stalled digest beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled digest beat changed");

  // Digest words leave back to back in index order.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tuser_o == 3'($past(m_axis_tuser_o) + 3'd1)))
    else $error("digest word index out of order");

  // Every digest starts at word zero.
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> (m_axis_tuser_o == 3'd0))
    else $error("digest does not start at word zero");

endmodule

bind sha256_message_hasher_core sha256h_checker u_sha256h_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the SHA-256 message hasher core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted beat before the run is declared hung. The
  // slowest legal stretch is two padded blocks plus a long receiver stall, so
  // this leaves a wide margin.
  localparam int unsigned StallLimit = 4000;
  // Quiet cycles after the last digest word, to catch stray output beats.
  localparam int unsigned SettleCycles = 300;
  // Message beats (byte or end marker) to send in the random phase.
  localparam int unsigned RandomBeats = 25;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // One expected digest beat on the master side.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic [0:0]  s_axis_tuser  = 1'b0;   // [0] byte_present
  logic        s_axis_tlast  = 1'b0;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] digest_word
  logic [2:0]  m_axis_tuser;           // [2:0] word_index
  logic        m_axis_tlast;           // last_word

  // Shadow of the hasher: chain value, partial block, fill level, length.
  logic [31:0] chain_shadow [8];
  logic [7:0]  block_shadow [64];
  int unsigned fill_shadow;
  logic [60:0] length_shadow;

  digest_beat_t digest_exp_q [$];

  int unsigned err_cnt      = 0;
  int unsigned msg_items    = 0;  // accepted beats carrying a byte or an end
  int unsigned msg_done     = 0;  // messages closed by an end beat
  int unsigned words_seen   = 0;
  int unsigned longest_msg  = 0;
  int unsigned idle_cycles  = 0;
  bit          idle_on      = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha256_message_hasher_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------
  // Hash prediction
  // ---------------------------------------------------------------------

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain_shadow[i] = HashInit[i];
    fill_shadow   = 0;
    length_shadow = '0;
  endtask

  // Run the 64-round compression over the 64 bytes in block_shadow.
  task automatic hash_block();
    logic [31:0] sched [64];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
    logic [31:0] sig_lo, sig_hi, mix1, mix2;
    for (int t = 0; t < 16; t++)
      sched[t] = {block_shadow[4*t], block_shadow[4*t+1],
                  block_shadow[4*t+2], block_shadow[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      sig_lo = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
      sig_hi = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = sched[t-16] + sig_lo + sched[t-7] + sig_hi;
    end
    va = chain_shadow[0]; vb = chain_shadow[1]; vc = chain_shadow[2]; vd = chain_shadow[3];
    ve = chain_shadow[4]; vf = chain_shadow[5]; vg = chain_shadow[6]; vh = chain_shadow[7];
    for (int t = 0; t < 64; t++) begin
      mix1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
           + ((ve & vf) ^ (~ve & vg)) + RoundConst[t] + sched[t];
      mix2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
           + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + mix1;
      vd = vc; vc = vb; vb = va; va = mix1 + mix2;
    end
    chain_shadow[0] += va; chain_shadow[1] += vb; chain_shadow[2] += vc;
    chain_shadow[3] += vd; chain_shadow[4] += ve; chain_shadow[5] += vf;
    chain_shadow[6] += vg; chain_shadow[7] += vh;
  endtask

  // Fold one accepted slave beat into the shadow; on an end beat, pad,
  // finish the hash and queue the eight digest words it must produce.
  task automatic absorb_beat(input logic [7:0] data, input logic present, input logic eom);
    logic [63:0] bit_len;
    if (present) begin
      block_shadow[fill_shadow] = data;
      fill_shadow++;
      length_shadow++;
      if (fill_shadow == 64) begin
        hash_block();
        fill_shadow = 0;
      end
    end
    if (eom) begin
      if (length_shadow > longest_msg) longest_msg = 32'(length_shadow);
      block_shadow[fill_shadow] = 8'h80;
      fill_shadow++;
      // Length no longer fits: close this block and pad a fresh one.
      if (fill_shadow > 56) begin
        while (fill_shadow < 64) begin
          block_shadow[fill_shadow] = 8'h00;
          fill_shadow++;
        end
        hash_block();
        fill_shadow = 0;
      end
      while (fill_shadow < 56) begin
        block_shadow[fill_shadow] = 8'h00;
        fill_shadow++;
      end
      bit_len = {length_shadow, 3'b000};
      for (int k = 0; k < 8; k++) block_shadow[56+k] = bit_len[63-8*k -: 8];
      hash_block();
      for (int k = 0; k < 8; k++)
        digest_exp_q.push_back('{word: chain_shadow[k], idx: k[2:0], last: (k == 7)});
      msg_done++;
      restart_message();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int unsigned next_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one slave beat and hold it until accepted. Entered and left at a
  // rising edge. tready is sampled at the falling edge before the accepting
  // edge, so the handshake never races the core's own updates.
  task automatic send_beat(input logic [7:0] data, input logic present, input logic eom);
    int unsigned gap;
    bit taken;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    absorb_beat(data, present, eom);
    if (present || eom) msg_items++;
  endtask

  // Send a whole message. The end rides on the last byte or on a separate
  // byteless beat; empty beats with junk data are sprinkled in as noise.
  task automatic send_message(input logic [7:0] msg [$], input bit end_on_byte,
                              input int unsigned noise_pct);
    for (int i = 0; i < msg.size(); i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(msg[i], 1'b1, end_on_byte && (i == msg.size() - 1));
    end
    if (!end_on_byte || msg.size() == 0)
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_random_message(input int unsigned len, input bit end_on_byte,
                                     input int unsigned noise_pct);
    logic [7:0] msg [$];
    repeat (len) msg.push_back(8'($urandom_range(0, 255)));
    send_message(msg, end_on_byte, noise_pct);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty message right after reset, then again right after a digest, the
  // second time with junk on the ignored data byte.
  task automatic test_empty_message();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b1);
  endtask

  // Byte value extremes, end on the byte and end on its own beat.
  task automatic test_byte_extremes();
    send_message('{8'h00}, 1'b1, 0);
    send_message('{8'hff}, 1'b0, 0);
    send_message('{8'h61, 8'h62, 8'h63}, 1'b1, 0);
  endtask

  // Empty beats must change nothing, whatever sits on the data byte.
  task automatic test_ignored_beats();
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_message('{8'h5a, 8'ha5}, 1'b1, 50);
    send_beat(8'h3c, 1'b0, 1'b0);
    send_beat(8'hc3, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
  endtask

  // Lengths around the padding edges: length fits, length spills, marker on
  // the last byte of a block, and a message that fills a block exactly.
  task automatic test_pad_boundaries();
    idle_on = 1'b0;
    send_random_message(55, 1'b1, 0);
    idle_on = 1'b1;
    send_random_message(56, 1'b0, 0);
    send_random_message(63, 1'b1, 0);
    send_random_message(64, 1'b1, 0);
  endtask

  // Short random messages, cut to fit the remaining beat budget; some
  // stretches run without any idling on either side.
  task automatic test_random_messages();
    int unsigned stop_at;
    int unsigned len;
    stop_at = msg_items + RandomBeats;
    while (msg_items < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(0, 24);
      if (len > stop_at - msg_items) len = stop_at - msg_items;
      send_random_message(len, 1'($urandom_range(0, 1)), 12);
    end
    idle_on = 1'b1;
  endtask

  // Drop valid, wait for every digest word, let the core settle, report.
  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (digest_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Hashed %0d messages from %0d message beats, longest %0d bytes.",
             msg_done, msg_items, longest_msg);
    $display("Checked %0d digest words, %0d mismatches.", words_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  initial begin
    restart_message();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_message();
    test_byte_extremes();
    test_ignored_beats();
    test_pad_boundaries();
    test_random_messages();
    finish_run();
  end

  // ---------------------------------------------------------------------
  // Receiver stalls: bursts of ready, broken by mostly short holds.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      hold = next_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------
  // Digest checker: compare each master beat with the oldest expectation.
  // Sampled at the falling edge; the beat completes at the next rising one.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (digest_exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected digest beat: word %h index %0d last %b",
                 $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        exp_beat = digest_exp_q.pop_front();
        if (m_axis_tdata !== exp_beat.word) begin
          err_cnt++;
          $display("%0t: digest word mismatch: expected %h, got %h",
                   $realtime, exp_beat.word, m_axis_tdata);
        end
        if (m_axis_tuser !== exp_beat.idx) begin
          err_cnt++;
          $display("%0t: word index mismatch: expected %0d, got %0d",
                   $realtime, exp_beat.idx, m_axis_tuser);
        end
        if (m_axis_tlast !== exp_beat.last) begin
          err_cnt++;
          $display("%0t: last word flag mismatch: expected %b, got %b",
                   $realtime, exp_beat.last, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == StallLimit) begin
        $display("%0t: no beat accepted for %0d cycles, %0d digest words pending",
                 $realtime, StallLimit, digest_exp_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
